// ----- sv/hll_rusanov_flux_top_macros.svh -----
// Assertion macros for the Riemann flux block
`ifndef HLL_RUSANOV_FLUX_TOP_MACROS_SVH
`define HLL_RUSANOV_FLUX_TOP_MACROS_SVH

// checked outside reset
`define HRF_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define HRF_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/hrf_pkg.sv -----
// Types and constants shared by the Riemann flux block
`timescale 1ns / 1ps
package hrf_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int NUM_W  = 99;              // exact HLL numerator width
  localparam int MAG_W  = NUM_W - FRAC_W;  // numerator magnitude after the 2^F scale
  localparam int QUO_W  = DATA_W + 1;      // quotient bits kept before clipping

  localparam logic SOLVER_RUSANOV = 1'b0;

  localparam logic REG_SOLVER_KIND = 1'b0;
  localparam logic REG_HALL_MODE   = 1'b1;

  typedef enum logic [1:0] {
    SEL_DIV   = 2'd0,
    SEL_LEFT  = 2'd1,
    SEL_RIGHT = 2'd2,
    SEL_ZERO  = 2'd3
  } sel_t;

  typedef struct packed {
    logic                     field_group;
    logic signed [DATA_W-1:0] flux_left;
    logic signed [DATA_W-1:0] flux_right;
    logic signed [DATA_W-1:0] state_left;
    logic signed [DATA_W-1:0] state_right;
    logic signed [DATA_W-1:0] speed_left;
    logic signed [DATA_W-1:0] speed_right;
    logic signed [DATA_W-1:0] speed_max;
    logic signed [DATA_W-1:0] speed_left_b;
    logic signed [DATA_W-1:0] speed_right_b;
    logic signed [DATA_W-1:0] speed_max_b;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] flux_out;
    logic                     saturated;
    logic                     degenerate;
  } out_t;

  // travels alongside the divider
  typedef struct packed {
    logic                     neg;
    sel_t                     sel;
    logic signed [DATA_W-1:0] val;
  } side_t;

endpackage

// ----- sv/hrf_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with overflow precheck
`timescale 1ns / 1ps
module hrf_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [hrf_pkg::MAG_W-1:0]  in_num,
  input  logic [hrf_pkg::QUO_W-1:0]  in_den,
  input  hrf_pkg::side_t             in_side,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [hrf_pkg::QUO_W-1:0]  out_quo,
  output logic                       out_ovf,
  output hrf_pkg::side_t             out_side
);
  import hrf_pkg::*;

  localparam int DEPTH = QUO_W + 1;

  logic               v    [DEPTH];
  logic               ce   [DEPTH];
  logic [QUO_W-1:0]   rem  [DEPTH];
  logic [QUO_W-1:0]   low  [DEPTH];
  logic [QUO_W-1:0]   quo  [DEPTH];
  logic [QUO_W-1:0]   den  [DEPTH];
  logic               ovf  [DEPTH];
  side_t              side [DEPTH];

  assign ce[DEPTH-1] = !v[DEPTH-1] || !out_stall;
  assign ce[0]       = !v[0] || ce[1];
  assign in_stall    = !ce[0];

  // head stage: quotient fits QUO_W bits unless the top part reaches the divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (ce[0]) begin
      v[0] <= in_valid;
    end
    if (ce[0]) begin
      ovf[0]  <= in_num[MAG_W-1:QUO_W] >= (MAG_W-QUO_W)'(in_den);
      rem[0]  <= in_num[2*QUO_W-1:QUO_W];
      low[0]  <= in_num[QUO_W-1:0];
      quo[0]  <= '0;
      den[0]  <= in_den;
      side[0] <= in_side;
    end
  end

  for (genvar k = 1; k < DEPTH; k++) begin : g_step
    logic [QUO_W:0] trial;
    logic [QUO_W:0] diff;

    if (k < DEPTH - 1) begin : g_ce
      assign ce[k] = !v[k] || ce[k+1];
    end

    assign trial = {rem[k-1], low[k-1][QUO_W-1]};
    assign diff  = trial - {1'b0, den[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (ce[k]) begin
        v[k] <= v[k-1];
      end
      if (ce[k]) begin
        rem[k]  <= diff[QUO_W] ? trial[QUO_W-1:0] : diff[QUO_W-1:0];
        quo[k]  <= {quo[k-1][QUO_W-2:0], !diff[QUO_W]};
        low[k]  <= {low[k-1][QUO_W-2:0], 1'b0};
        den[k]  <= den[k-1];
        ovf[k]  <= ovf[k-1];
        side[k] <= side[k-1];
      end
    end
  end

  assign out_valid = v[DEPTH-1];
  assign out_quo   = quo[DEPTH-1];
  assign out_ovf   = ovf[DEPTH-1];
  assign out_side  = side[DEPTH-1];

endmodule

// ----- sv/hll_rusanov_flux_top.sv -----
// Rusanov / HLL interface flux, signed fixed point, fully pipelined
//
//  channel | direction | handshake          | payload
//  in      | into      | in_valid/in_stall  | in_data (hrf_pkg::in_t)
//  out     | out of    | out_valid/out_stall| out_data (hrf_pkg::out_t)
//  cfg     | into      | cfg_we             | cfg_index, cfg_data
//
// One transfer per cycle sustained while out_stall is low; five arithmetic stages,
// 34 divider stages (precheck plus one quotient bit each) and the output register.
// Synchronous reset empties the pipeline and loads solver_kind = HLL, hall_mode off.
// Each stage holds only while the one after it is full and held, so bubbles close up.
`timescale 1ns / 1ps
`include "hll_rusanov_flux_top_macros.svh"
module hll_rusanov_flux_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  hrf_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output hrf_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic          cfg_data
);
  import hrf_pkg::*;

  logic solver_kind;
  logic hall_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      solver_kind <= 1'b1;
      hall_mode   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOLVER_KIND: solver_kind <= cfg_data;
        REG_HALL_MODE:   hall_mode   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic v_a, v_b, v_c, v_d, v_e;
  logic ce_a, ce_b, ce_c, ce_d, ce_e;
  logic div_stall;

  assign ce_e     = !v_e || !div_stall;
  assign ce_d     = !v_d || ce_e;
  assign ce_c     = !v_c || ce_d;
  assign ce_b     = !v_b || ce_c;
  assign ce_a     = !v_a || ce_b;
  assign in_stall = !ce_a;

  // stage A: speed selection, sums, differences, branch choice
  logic                     bgrp;
  logic signed [DATA_W-1:0] sl_in, sr_in, s_in;
  sel_t                     sel_in;

  assign bgrp  = hall_mode && in_data.field_group;
  assign sl_in = bgrp ? in_data.speed_left_b  : in_data.speed_left;
  assign sr_in = bgrp ? in_data.speed_right_b : in_data.speed_right;
  assign s_in  = bgrp ? in_data.speed_max_b   : in_data.speed_max;

  always_comb begin
    if (solver_kind == SOLVER_RUSANOV) sel_in = SEL_DIV;
    else if (sl_in > 0)                sel_in = SEL_LEFT;
    else if (sr_in < 0)                sel_in = SEL_RIGHT;
    else if (sr_in == sl_in)           sel_in = SEL_ZERO;
    else                               sel_in = SEL_DIV;
  end

  logic signed [DATA_W-1:0] fl_a, fr_a, sl_a, sr_a, s_a;
  logic signed [DATA_W:0]   du_a, ssum_a, dd_a;
  logic                     rus_a;
  sel_t                     sel_a;

  always_ff @(posedge clk) begin
    if (rst) v_a <= 1'b0;
    else if (ce_a) v_a <= in_valid;
    if (ce_a) begin
      fl_a   <= in_data.flux_left;
      fr_a   <= in_data.flux_right;
      sl_a   <= sl_in;
      sr_a   <= sr_in;
      s_a    <= s_in;
      du_a   <= (DATA_W+1)'(in_data.state_right) - (DATA_W+1)'(in_data.state_left);
      ssum_a <= (DATA_W+1)'(in_data.flux_left) + (DATA_W+1)'(in_data.flux_right);
      dd_a   <= (DATA_W+1)'(sr_in) - (DATA_W+1)'(sl_in);
      rus_a  <= solver_kind == SOLVER_RUSANOV;
      sel_a  <= sel_in;
    end
  end

  // stage B: first products
  logic signed [2*DATA_W-1:0] p1_b, p2_b, p3_b;
  logic signed [2*DATA_W:0]   p4_b;
  logic signed [DATA_W:0]     du_b, ssum_b, dd_b;
  logic signed [DATA_W-1:0]   fl_b, fr_b;
  logic                       rus_b;
  sel_t                       sel_b;

  always_ff @(posedge clk) begin
    if (rst) v_b <= 1'b0;
    else if (ce_b) v_b <= v_a;
    if (ce_b) begin
      p1_b   <= sr_a * fl_a;
      p2_b   <= sl_a * fr_a;
      p3_b   <= sl_a * sr_a;
      p4_b   <= (2*DATA_W+1)'(s_a) * (2*DATA_W+1)'(du_a);
      du_b   <= du_a;
      ssum_b <= ssum_a;
      dd_b   <= dd_a;
      fl_b   <= fl_a;
      fr_b   <= fr_a;
      rus_b  <= rus_a;
      sel_b  <= sel_a;
    end
  end

  // stage C: SL*SR*du split in two halves, flux cross term, Rusanov numerator
  logic signed [2*DATA_W:0]   x_c, ph_c;
  logic signed [2*DATA_W+1:0] pl_c;
  logic signed [NUM_W-1:0]    nr_c;
  logic signed [DATA_W:0]     dd_c;
  logic signed [DATA_W-1:0]   fl_c, fr_c;
  logic                       rus_c;
  sel_t                       sel_c;

  always_ff @(posedge clk) begin
    if (rst) v_c <= 1'b0;
    else if (ce_c) v_c <= v_b;
    if (ce_c) begin
      x_c   <= (2*DATA_W+1)'(p1_b) - (2*DATA_W+1)'(p2_b);
      ph_c  <= (2*DATA_W+1)'($signed(p3_b[2*DATA_W-1:DATA_W])) * (2*DATA_W+1)'(du_b);
      pl_c  <= (2*DATA_W+2)'($signed({1'b0, p3_b[DATA_W-1:0]})) * (2*DATA_W+2)'(du_b);
      nr_c  <= (NUM_W'(ssum_b) <<< FRAC_W) - NUM_W'(p4_b);
      dd_c  <= dd_b;
      fl_c  <= fl_b;
      fr_c  <= fr_b;
      rus_c <= rus_b;
      sel_c <= sel_b;
    end
  end

  // stage D: full numerator and divisor
  logic signed [NUM_W-1:0]  n_d;
  logic [QUO_W-1:0]         den_d;
  logic signed [DATA_W-1:0] fl_d, fr_d;
  sel_t                     sel_d;

  always_ff @(posedge clk) begin
    if (rst) v_d <= 1'b0;
    else if (ce_d) v_d <= v_c;
    if (ce_d) begin
      n_d   <= rus_c ? nr_c
                     : (NUM_W'(x_c) <<< FRAC_W) + (NUM_W'(ph_c) <<< DATA_W) + NUM_W'(pl_c);
      // Rusanov: divide by 2^(F+1) as (|n| >> F) / 2
      den_d <= rus_c ? QUO_W'(2) : dd_c;
      fl_d  <= fl_c;
      fr_d  <= fr_c;
      sel_d <= sel_c;
    end
  end

  // stage E: sign and magnitude, drop the 2^F scale of the divisor
  logic [NUM_W-1:0]  nmag;
  logic [MAG_W-1:0]  m_e;
  logic [QUO_W-1:0]  den_e;
  side_t             side_e;

  assign nmag = n_d[NUM_W-1] ? NUM_W'(-n_d) : NUM_W'(n_d);

  always_ff @(posedge clk) begin
    if (rst) v_e <= 1'b0;
    else if (ce_e) v_e <= v_d;
    if (ce_e) begin
      m_e        <= nmag[NUM_W-1:FRAC_W];
      den_e      <= den_d;
      side_e.neg <= n_d[NUM_W-1];
      side_e.sel <= sel_d;
      side_e.val <= (sel_d == SEL_RIGHT) ? fr_d : fl_d;
    end
  end

  logic             dv;
  logic             d_stall;
  logic [QUO_W-1:0] d_quo;
  logic             d_ovf;
  side_t            d_side;

  hrf_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v_e),
    .in_stall  (div_stall),
    .in_num    (m_e),
    .in_den    (den_e),
    .in_side   (side_e),
    .out_valid (dv),
    .out_stall (d_stall),
    .out_quo   (d_quo),
    .out_ovf   (d_ovf),
    .out_side  (d_side)
  );

  // output register: clip, sign, branch select
  logic             ce_o;
  logic [QUO_W-1:0] lim;
  logic             sat;
  logic [QUO_W-1:0] qmag;
  logic [QUO_W-1:0] qres;
  out_t             res;

  assign ce_o    = !out_valid || !out_stall;
  assign d_stall = !ce_o;
  assign lim     = d_side.neg ? (QUO_W'(1) << (DATA_W-1)) : ((QUO_W'(1) << (DATA_W-1)) - 1'b1);
  assign sat     = d_ovf || (d_quo > lim);
  assign qmag    = sat ? lim : d_quo;
  assign qres    = d_side.neg ? QUO_W'(-qmag) : qmag;

  always_comb begin
    res = '0;
    case (d_side.sel)
      SEL_DIV: begin
        res.flux_out  = qres[DATA_W-1:0];
        res.saturated = sat;
      end
      SEL_LEFT, SEL_RIGHT: res.flux_out = d_side.val;
      SEL_ZERO: res.degenerate = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ce_o) out_valid <= dv;
    if (ce_o) out_data <= res;
  end

  `HRF_CHECK(a_deg_zero, out_valid && out_data.degenerate |-> out_data.flux_out == '0, "degenerate result not zero")
  `HRF_CHECK(a_flags_excl, out_valid |-> !(out_data.degenerate && out_data.saturated), "both flags set")
  `HRF_CHECK_ALWAYS(a_rst_empty, $past(rst) |-> !out_valid && !v_a, "pipeline not empty after reset")
  `HRF_CHECK(a_div_hold, dv && d_stall |=> dv, "divider lost a result while held")

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the Rusanov / HLL interface flux block
`timescale 1ns / 1ps
module tb_top;
  import hrf_pkg::*;

  localparam int SETTLE_CYC = 60;    // beyond the pipeline latency
  localparam int IDLE_LIMIT = 5000;  // cycles without a transfer before giving up

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  in_t  in_data;
  out_t out_data;
  logic cfg_we, cfg_index, cfg_data;

  hll_rusanov_flux_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  out_t pending_flux[$];
  logic solver_sel;
  logic hall_en;
  int   n_sent, n_checked, n_errors, n_sat, n_degen, idle_cycles;
  logic rx_quiet;
  bit   in_done, out_done;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Expected flux, held exactly in 128 bits and clipped at the end
  function automatic out_t predict_flux(in_t x, logic solver, logic hall);
    logic signed [127:0] fl, fr, ul, ur, du, sl, sr, sm, num, den, q, hi, lo;
    logic bg;
    out_t r;
    bg = hall && x.field_group;
    fl = x.flux_left;
    fr = x.flux_right;
    ul = x.state_left;
    ur = x.state_right;
    du = ur - ul;
    sl = bg ? x.speed_left_b : x.speed_left;
    sr = bg ? x.speed_right_b : x.speed_right;
    sm = bg ? x.speed_max_b : x.speed_max;
    hi = 128'sd2147483647;
    lo = -128'sd2147483648;
    r = '0;
    num = 0;
    den = 0;
    if (solver == SOLVER_RUSANOV) begin
      num = ((fl + fr) <<< FRAC_W) - sm * du;
      den = 1;
      den = den <<< (FRAC_W + 1);
    end else if (sl > 0) begin
      r.flux_out = x.flux_left;
    end else if (sr < 0) begin
      r.flux_out = x.flux_right;
    end else if (sr == sl) begin
      r.degenerate = 1'b1;
    end else begin
      num = ((fl * sr - fr * sl) <<< FRAC_W) + sl * sr * du;
      den = (sr - sl) <<< FRAC_W;
    end
    if (den != 0) begin
      q = num / den;  // truncates toward zero
      if (q > hi) begin
        q = hi;
        r.saturated = 1'b1;
      end else if (q < lo) begin
        q = lo;
        r.saturated = 1'b1;
      end
      r.flux_out = q[DATA_W-1:0];
    end
    return r;
  endfunction

  // drives in_valid high until the transfer is taken; returns after the accepting edge
  task automatic send_item(in_t x);
    in_valid <= 1'b1;
    in_data  <= x;
    forever begin
      @(negedge clk);
      if (!in_stall) begin
        pending_flux.push_back(predict_flux(x, solver_sel, hall_en));
        n_sent++;
        @(posedge clk);
        break;
      end
      @(posedge clk);
    end
  endtask

  task automatic pause_input(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_flux.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic val);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SOLVER_KIND) solver_sel = val;
    else hall_en = val;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  // speeds sometimes straddling zero so the HLL average is exercised
  function automatic in_t rand_item();
    in_t x;
    logic [31:0] a, b;
    x.field_group = 1'($urandom_range(0, 1));
    x.flux_left   = rand_word();
    x.flux_right  = rand_word();
    x.state_left  = rand_word();
    x.state_right = rand_word();
    x.speed_max   = rand_word();
    x.speed_max_b = rand_word();
    for (int k = 0; k < 2; k++) begin
      case ($urandom_range(0, 5))
        0: begin a = rand_word(); b = rand_word(); end
        1: begin a = 0; b = 0; end
        2: begin a = $urandom_range(1, 32'h0010_0000); b = a + $urandom_range(0, 65536); end
        3: begin b = -$urandom_range(1, 32'h0010_0000); a = b - $urandom_range(0, 65536); end
        default: begin
          a = -$urandom_range(0, 32'h0040_0000);
          b = $urandom_range(0, 32'h0040_0000);
        end
      endcase
      if (k == 0) begin
        x.speed_left  = a;
        x.speed_right = b;
      end else begin
        x.speed_left_b  = a;
        x.speed_right_b = b;
      end
    end
    return x;
  endfunction

  // random traffic, bursty when bursty is set; one mid-run pause until all results are back
  task automatic run_random(int count, bit bursty);
    int burst;
    burst = $urandom_range(1, 20);
    for (int i = 0; i < count; i++) begin
      send_item(rand_item());
      if (i == count / 2) drain_results();
      if (bursty && --burst == 0) begin
        pause_input($urandom_range(1, 6));
        burst = $urandom_range(1, 20);
      end
    end
  endtask

  task automatic test_directed_hll();
    in_t x;
    x = '0;
    send_item(x);                                    // SL = SR = 0: degenerate
    x.flux_left = 32'h7fff_ffff; x.flux_right = 32'h8000_0000;
    x.speed_left = 32'h0001_0000; x.speed_right = 32'h0002_0000;
    send_item(x);                                    // SL > 0: left flux
    x.speed_left = 32'h8000_0000; x.speed_right = 32'hffff_0000;
    send_item(x);                                    // SR < 0: right flux
    x.speed_left = 32'h8000_0000; x.speed_right = 32'h7fff_ffff;
    x.state_left = 32'h8000_0000; x.state_right = 32'h7fff_ffff;
    send_item(x);                                    // extremes, saturates
    x.state_left = 32'h7fff_ffff; x.state_right = 32'h8000_0000;
    send_item(x);
    x.speed_left = 32'hffff_0000; x.speed_right = 32'h0001_0000;
    x.flux_left = 32'h0003_0000; x.flux_right = 32'h0001_0000;
    x.state_left = 32'h0001_0000; x.state_right = 32'h0002_0000;
    send_item(x);                                    // ordinary HLL average
    x.speed_left = 0;
    send_item(x);                                    // SL = 0 edge
    x.speed_left = 32'hffff_0000; x.speed_right = 0;
    send_item(x);                                    // SR = 0 edge
    x.field_group = 1'b1; x.speed_left_b = 32'h0005_0000;
    send_item(x);                                    // group bit ignored, hall off
  endtask

  task automatic test_directed_rusanov();
    in_t x;
    x = '0;
    send_item(x);
    x.flux_left = 32'h7fff_ffff; x.flux_right = 32'h7fff_ffff;
    send_item(x);
    x.speed_max = 32'h8000_0000; x.state_left = 32'h8000_0000;
    x.state_right = 32'h7fff_ffff;
    send_item(x);                                    // negative speed used as given
    x.speed_max = 32'h7fff_ffff;
    send_item(x);
    x.flux_left = 32'h8000_0000; x.flux_right = 32'h8000_0000;
    send_item(x);
    x = '0; x.flux_left = 32'hffff_ffff;
    send_item(x);                                    // -1 ulp halves toward zero
    x.field_group = 1'b1; x.speed_max_b = 32'h0002_0000; x.state_right = 32'h0001_0000;
    send_item(x);
  endtask

  task automatic test_hall_group();
    in_t x;
    x = '0;
    x.field_group = 1'b1;
    x.flux_left = 32'h0004_0000; x.flux_right = 32'h0002_0000;
    x.speed_left = 32'h0001_0000; x.speed_right = 32'h0002_0000;
    x.speed_left_b = 32'hfffe_0000; x.speed_right_b = 32'h0003_0000;
    x.state_right = 32'h0001_8000;
    send_item(x);
    x.speed_left_b = 0; x.speed_right_b = 0;
    send_item(x);                                    // degenerate through b-speeds
    x.field_group = 1'b0;
    send_item(x);
  endtask

  // result checker: outputs are stable at the falling edge
  always @(negedge clk) begin
    out_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_flux.size() == 0) begin
        $error("unexpected result flux_out=%0d", $signed(out_data.flux_out));
        n_errors++;
      end else begin
        exp_r = pending_flux.pop_front();
        n_checked++;
        n_sat   += exp_r.saturated;
        n_degen += exp_r.degenerate;
        if (out_data.flux_out !== exp_r.flux_out) begin
          $error("flux_out: expected %0d, got %0d", $signed(exp_r.flux_out),
                 $signed(out_data.flux_out));
          n_errors++;
        end
        if (out_data.saturated !== exp_r.saturated) begin
          $error("saturated: expected %0b, got %0b", exp_r.saturated, out_data.saturated);
          n_errors++;
        end
        if (out_data.degenerate !== exp_r.degenerate) begin
          $error("degenerate: expected %0b, got %0b", exp_r.degenerate, out_data.degenerate);
          n_errors++;
        end
      end
    end
    in_done  <= !rst && in_valid && !in_stall;
    out_done <= !rst && out_valid && !out_stall;
  end

  // receiver stall runs
  always @(posedge clk) begin
    int run_len;
    if (rst) begin
      out_stall <= 1'b0;
      run_len = 0;
    end else if (run_len > 0) begin
      run_len--;
    end else begin
      out_stall <= rx_quiet ? 1'b0 : ($urandom_range(0, 2) == 0);
      run_len = $urandom_range(0, 7);
    end
  end

  always @(posedge clk) begin
    if (rst || in_done || out_done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_SOLVER_KIND;
    cfg_data  <= 1'b0;
    rx_quiet   = 1'b0;
    solver_sel = 1'b1;
    hall_en    = 1'b0;
    n_sent = 0; n_checked = 0; n_errors = 0; n_sat = 0; n_degen = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_hll();
    write_reg(REG_HALL_MODE, 1'b1);
    test_hall_group();
    write_reg(REG_SOLVER_KIND, SOLVER_RUSANOV);
    test_directed_rusanov();
    run_random(300, 1'b1);
    write_reg(REG_HALL_MODE, 1'b0);
    rx_quiet = 1'b1;
    run_random(250, 1'b0);                           // back-to-back, no stalls
    rx_quiet = 1'b0;
    write_reg(REG_SOLVER_KIND, ~SOLVER_RUSANOV);
    run_random(400, 1'b1);
    write_reg(REG_HALL_MODE, 1'b1);
    run_random(380, 1'b1);
    drain_results();

    $display("covered %0d items over both solvers and both Hall settings", n_sent);
    $display("checked %0d results: %0d clipped, %0d with zero denominator",
             n_checked, n_sat, n_degen);
    if (n_errors == 0 && pending_flux.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/hrf_pkg.sv
sv/hrf_div.sv
sv/hll_rusanov_flux_top.sv
tb/sv/tb_top.sv
